// ===== rtl/sleep_wakeup_timer_queue_top_macros.svh =====
// assertion macros for the sleep/wakeup timer queue
// used by sleep_wakeup_timer_queue_top; no other dependencies
`ifndef SLEEP_WAKEUP_TIMER_QUEUE_TOP_MACROS_SVH
`define SLEEP_WAKEUP_TIMER_QUEUE_TOP_MACROS_SVH

// cond must never hold outside reset
`define SWTQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

// whenever cond holds, prop holds in the same cycle
`define SWTQ_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ===== rtl/swtq_pkg.sv =====
// shared types and constants of the sleep/wakeup timer queue
// no dependencies
package swtq_pkg;

    localparam int TASK_W = 6;
    localparam int SECS_W = 16;
    localparam int TPS_W  = 24;
    // non-negative seconds times ticks per second
    localparam int PROD_W = SECS_W - 1 + TPS_W;

    localparam logic [TPS_W-1:0] TPS_RESET = 24'd1000000;

    typedef enum logic {
        OP_SLEEP = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_NEGATIVE = 3'd1,
        ST_FULL     = 3'd2,
        ST_WOKEN    = 3'd3,
        ST_NONE     = 3'd4
    } t_status;

    // classified command handed from front to back
    typedef struct packed {
        t_op               op;
        logic              neg;
        logic [TASK_W-1:0] task_id;
    } t_cmd_ctl;

    typedef struct packed {
        t_status           status;
        logic [TASK_W-1:0] woken_id;
        logic              last;
    } t_result;

endpackage

// ===== rtl/swtq_cmd_fifo.sv =====
// two-entry command queue between front and back
// depends on nothing but its width parameter
module swtq_cmd_fifo #(
    parameter int W = 56
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_push_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_pop_data,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    assign o_pop_data = r_mem[r_rd];
    assign o_full     = r_cnt[1];
    assign o_empty    = (r_cnt == 2'd0);

endmodule

// ===== rtl/swtq_front.sv =====
// front end: takes input transactions, flags negative seconds, works out wake time
// depends on swtq_pkg; feeds swtq_cmd_fifo
module swtq_front #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_op,
    input  logic [swtq_pkg::TASK_W-1:0]  i_task_id,
    input  logic signed [swtq_pkg::SECS_W-1:0] i_sleep_seconds,
    input  logic [TIME_WIDTH-1:0]        i_now_ticks,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [swtq_pkg::TPS_W-1:0]   i_cfg_data,
    output logic                         o_push,
    output swtq_pkg::t_cmd_ctl           o_push_ctl,
    output logic [TIME_WIDTH-1:0]        o_push_time,
    input  logic                         i_fifo_full
);

    localparam int PW = swtq_pkg::PROD_W;
    localparam int SW = ((TIME_WIDTH > PW) ? TIME_WIDTH : PW) + 1;

    logic                          r_s1_valid;
    swtq_pkg::t_cmd_ctl            r_s1_ctl;
    logic [TIME_WIDTH-1:0]         r_s1_now;
    logic [PW-1:0]                 r_s1_prod;
    logic [swtq_pkg::TPS_W-1:0]    r_tps;

    logic          w_adv;
    logic          w_accept;
    logic [PW-1:0] w_prod;
    logic [SW-1:0] w_sum;
    logic          w_sat;
    logic [TIME_WIDTH-1:0] w_wake;

    assign w_adv       = !r_s1_valid || !i_fifo_full;
    assign w_accept    = i_in_valid && w_adv;
    assign o_in_stall  = !w_adv;
    assign o_cfg_ready = 1'b1;

    // sign bit cleared: negative requests never use the product
    assign w_prod = {{swtq_pkg::TPS_W{1'b0}}, i_sleep_seconds[swtq_pkg::SECS_W-2:0]}
                  * {{(swtq_pkg::SECS_W-1){1'b0}}, r_tps};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_tps      <= swtq_pkg::TPS_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_tps <= i_cfg_data;
            end
            if (w_adv) begin
                r_s1_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_ctl.op      <= swtq_pkg::t_op'(i_op);
            r_s1_ctl.neg     <= i_sleep_seconds[swtq_pkg::SECS_W-1];
            r_s1_ctl.task_id <= i_task_id;
            r_s1_now         <= i_now_ticks;
            r_s1_prod        <= w_prod;
        end
    end

    // saturate wake time at the top of the time range
    assign w_sum  = SW'(r_s1_now) + SW'(r_s1_prod);
    assign w_sat  = |w_sum[SW-1:TIME_WIDTH];
    assign w_wake = w_sat ? {TIME_WIDTH{1'b1}} : w_sum[TIME_WIDTH-1:0];

    assign o_push      = r_s1_valid && !i_fifo_full;
    assign o_push_ctl  = r_s1_ctl;
    assign o_push_time = (r_s1_ctl.op == swtq_pkg::OP_TICK) ? r_s1_now : w_wake;

endmodule

// ===== rtl/swtq_back.sv =====
// back end: sorted circular buffer of sleeping tasks in one memory, plus result register
// depends on swtq_pkg; fed by swtq_cmd_fifo
module swtq_back #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_WIDTH  = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  swtq_pkg::t_cmd_ctl    i_cmd_ctl,
    input  logic [TIME_WIDTH-1:0] i_cmd_time,
    output logic                  o_cmd_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output swtq_pkg::t_result     o_result
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = swtq_pkg::TASK_W + TIME_WIDTH;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_INS_CMP = 5'b00010,
        S_INS_WR  = 5'b00100,
        S_TK_CMP  = 5'b01000,
        S_TK_FIN  = 5'b10000
    } t_state;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        f_next = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_prev(input logic [AW-1:0] p);
        f_prev = (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - AW'(1);
    endfunction

    logic [EW-1:0] r_mem [QUEUE_DEPTH];
    logic [EW-1:0] r_rdata;

    t_state                      r_state, n_state;
    logic [AW-1:0]               r_head, n_head;
    logic [AW-1:0]               r_tail, n_tail;
    logic [CW-1:0]               r_count, n_count;
    logic [AW-1:0]               r_pos, n_pos;
    logic [CW-1:0]               r_left, n_left;
    swtq_pkg::t_cmd_ctl          r_ctl, n_ctl;
    logic [TIME_WIDTH-1:0]       r_time, n_time;
    logic [swtq_pkg::TASK_W-1:0] r_pend, n_pend;
    logic                        r_have_pend, n_have_pend;
    logic                        r_out_valid, n_out_valid;
    swtq_pkg::t_result           r_out, n_out;

    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [EW-1:0]         w_wr_data;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic                  w_out_free;
    logic [TIME_WIDTH-1:0] w_rd_wake;
    logic [swtq_pkg::TASK_W-1:0] w_rd_task;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_rd_wake  = r_rdata[TIME_WIDTH-1:0];
    assign w_rd_task  = r_rdata[EW-1:TIME_WIDTH];

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_pos       = r_pos;
        n_left      = r_left;
        n_ctl       = r_ctl;
        n_time      = r_time;
        n_pend      = r_pend;
        n_have_pend = r_have_pend;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_pos;
        w_wr_data   = r_rdata;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_head;
        o_cmd_pop   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    o_cmd_pop = 1'b1;
                    n_ctl     = i_cmd_ctl;
                    n_time    = i_cmd_time;
                    if (i_cmd_ctl.op == swtq_pkg::OP_SLEEP) begin
                        if (i_cmd_ctl.neg) begin
                            n_out_valid = 1'b1;
                            n_out       = '{swtq_pkg::ST_NEGATIVE, '0, 1'b1};
                        end else if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_out_valid = 1'b1;
                            n_out       = '{swtq_pkg::ST_FULL, '0, 1'b1};
                        end else if (r_count == '0) begin
                            w_wr_en     = 1'b1;
                            w_wr_addr   = r_tail;
                            w_wr_data   = {i_cmd_ctl.task_id, i_cmd_time};
                            n_tail      = f_next(r_tail);
                            n_count     = r_count + CW'(1);
                            n_out_valid = 1'b1;
                            n_out       = '{swtq_pkg::ST_ACCEPTED, '0, 1'b1};
                        end else begin
                            // walk back from the tail, shifting later entries up
                            n_pos     = r_tail;
                            n_left    = r_count;
                            w_rd_en   = 1'b1;
                            w_rd_addr = f_prev(r_tail);
                            n_state   = S_INS_CMP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_out_valid = 1'b1;
                            n_out       = '{swtq_pkg::ST_NONE, '0, 1'b1};
                        end else begin
                            n_have_pend = 1'b0;
                            w_rd_en     = 1'b1;
                            w_rd_addr   = r_head;
                            n_state     = S_TK_CMP;
                        end
                    end
                end
            end
            S_INS_CMP: begin
                // strictly later wake times move up, equal ones stay ahead
                if (w_rd_wake > r_time) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_pos;
                    w_wr_data = r_rdata;
                    n_pos     = f_prev(r_pos);
                    n_left    = r_left - CW'(1);
                    if (r_left != CW'(1)) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = f_prev(f_prev(r_pos));
                    end else begin
                        n_state = S_INS_WR;
                    end
                end else begin
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                if (w_out_free) begin
                    w_wr_en     = 1'b1;
                    w_wr_addr   = r_pos;
                    w_wr_data   = {r_ctl.task_id, r_time};
                    n_tail      = f_next(r_tail);
                    n_count     = r_count + CW'(1);
                    n_out_valid = 1'b1;
                    n_out       = '{swtq_pkg::ST_ACCEPTED, '0, 1'b1};
                    n_state     = S_IDLE;
                end
            end
            S_TK_CMP: begin
                // one task held back so that the last flag is known when it goes out
                if (w_rd_wake <= r_time) begin
                    if (!r_have_pend || w_out_free) begin
                        if (r_have_pend) begin
                            n_out_valid = 1'b1;
                            n_out       = '{swtq_pkg::ST_WOKEN, r_pend, 1'b0};
                        end
                        n_pend      = w_rd_task;
                        n_have_pend = 1'b1;
                        n_head      = f_next(r_head);
                        n_count     = r_count - CW'(1);
                        if (r_count != CW'(1)) begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = f_next(r_head);
                        end else begin
                            n_state = S_TK_FIN;
                        end
                    end
                end else begin
                    n_state = S_TK_FIN;
                end
            end
            S_TK_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_have_pend) begin
                        n_out = '{swtq_pkg::ST_WOKEN, r_pend, 1'b1};
                    end else begin
                        n_out = '{swtq_pkg::ST_NONE, '0, 1'b1};
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_have_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_have_pend <= n_have_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_left <= n_left;
        r_ctl  <= n_ctl;
        r_time <= n_time;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

// ===== rtl/sleep_wakeup_timer_queue_top.sv =====
// top level of the sleep/wakeup timer queue: front end, command queue, back end
// depends on swtq_pkg, swtq_front, swtq_cmd_fifo, swtq_back and the macros header

// Timer queue of sleeping tasks kept sorted by wake time in a single memory of
// QUEUE_DEPTH entries used as a circular buffer. The front end works out the wake time
// of a sleep transaction (now plus seconds times ticks per second, saturated) and puts
// the transaction into a two-entry command queue from a register stage after acceptance,
// from which the back end takes it up when idle and the result register is free. In the
// back end a rejected sleep, a sleep into an empty queue and a tick with nothing queued
// are answered directly from idle. Any other sleep walks back from the tail past every
// queued entry with a later wake time, shifting entries one per cycle through the
// single memory port, then writes the new entry. Any other tick releases due tasks from
// the head. Results leave earliest first, ties in insertion order, through one result
// register between the back end and the output, and output stalls hold the back end
// back. No clearing pass is needed after reset.
`include "sleep_wakeup_timer_queue_top_macros.svh"

module sleep_wakeup_timer_queue_top #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_WIDTH  = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_op,
    input  logic [swtq_pkg::TASK_W-1:0] i_task_id,
    input  logic signed [swtq_pkg::SECS_W-1:0] i_sleep_seconds,
    input  logic [TIME_WIDTH-1:0]       i_now_ticks,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [2:0]                  o_status,
    output logic [swtq_pkg::TASK_W-1:0] o_woken_id,
    output logic                        o_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [swtq_pkg::TPS_W-1:0]  i_cfg_data
);

    localparam int W = $bits(swtq_pkg::t_cmd_ctl) + TIME_WIDTH;

    logic                  w_push;
    swtq_pkg::t_cmd_ctl    w_push_ctl;
    logic [TIME_WIDTH-1:0] w_push_time;
    logic                  w_fifo_full;
    logic                  w_fifo_empty;
    logic                  w_pop;
    logic [W-1:0]          w_pop_data;
    swtq_pkg::t_cmd_ctl    w_pop_ctl;
    swtq_pkg::t_result     w_result;
    logic                  w_out_single;

    swtq_front #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_task_id      (i_task_id),
        .i_sleep_seconds(i_sleep_seconds),
        .i_now_ticks    (i_now_ticks),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_push         (w_push),
        .o_push_ctl     (w_push_ctl),
        .o_push_time    (w_push_time),
        .i_fifo_full    (w_fifo_full)
    );

    swtq_cmd_fifo #(
        .W(W)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_data({w_push_ctl, w_push_time}),
        .o_full     (w_fifo_full),
        .i_pop      (w_pop),
        .o_pop_data (w_pop_data),
        .o_empty    (w_fifo_empty)
    );

    assign w_pop_ctl = swtq_pkg::t_cmd_ctl'(w_pop_data[W-1:TIME_WIDTH]);

    swtq_back #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(!w_fifo_empty),
        .i_cmd_ctl  (w_pop_ctl),
        .i_cmd_time (w_pop_data[TIME_WIDTH-1:0]),
        .o_cmd_pop  (w_pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_result   (w_result)
    );

    assign o_status   = w_result.status;
    assign o_woken_id = w_result.woken_id;
    assign o_last     = w_result.last;

    assign w_out_single = o_out_valid && (o_status != swtq_pkg::ST_WOKEN);

    // front end must hold its transaction while the command queue is full
    `SWTQ_ASSERT_NEVER(a_push_into_full, i_clk, i_rst_n, w_push && w_fifo_full, "push when full")
    // only a full command queue may hold off the input side
    `SWTQ_ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, o_in_stall, w_fifo_full, "needless stall")
    // every result other than a woken task is the only one of its transaction
    `SWTQ_ASSERT_IMPLY(a_single_last, i_clk, i_rst_n, w_out_single, o_last, "lone result not last")

endmodule

// ===== tb/sleep_wakeup_timer_queue_top_test.sv =====
// self-checking testbench for the sleep/wakeup timer queue top level
// depends on swtq_pkg and sleep_wakeup_timer_queue_top; a sorted-queue predictor
// checks a directed table and then phases of random sleeps and ticks
`timescale 1ns / 100ps

module sleep_wakeup_timer_queue_top_test;
    import swtq_pkg::*;

    localparam int QDEPTH = 64;
    localparam int TIME_W = 48;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam int CLK_HALF = 5;
    localparam int SETTLE_CYCLES = QDEPTH + 16;
    localparam int QUIET_LIMIT = 5000;
    localparam int DIR_N = 16;

    typedef struct packed {
        t_op               op;
        logic [TASK_W-1:0] task_id;
        logic [SECS_W-1:0] secs;
        logic [TIME_W-1:0] now;
    } t_wake_req;

    typedef struct packed {
        t_wake_req req;
        logic      typed;
        t_result   res;
    } t_dir_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    localparam t_result UNTYPED = '{ST_ACCEPTED, 6'd0, 1'b0};

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_op = 1'b0;
    logic [TASK_W-1:0]   i_task_id = '0;
    logic signed [SECS_W-1:0] i_sleep_seconds = '0;
    logic [TIME_W-1:0]   i_now_ticks = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [2:0]          o_status;
    logic [TASK_W-1:0]   o_woken_id;
    logic                o_last;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [TPS_W-1:0]    i_cfg_data = '0;

    // predictor state: entries kept sorted by wake time, ties in arrival order
    logic [TIME_W-1:0]   queued_wake [QDEPTH];
    logic [TASK_W-1:0]   queued_task [QDEPTH];
    int                  queued_count = 0;
    logic [TPS_W-1:0]    rate_tps = TPS_RESET;

    t_result             awaited_results[$];
    t_result             fresh_results[$];
    t_dir_row            directed_rows [DIR_N];
    logic [63:0]         cur_now = '0;
    int                  burst_left = 0;
    int                  fail_count = 0;
    int                  quiet_cycles = 0;

    sleep_wakeup_timer_queue_top #(
        .QUEUE_DEPTH(QDEPTH),
        .TIME_WIDTH (TIME_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_task_id      (i_task_id),
        .i_sleep_seconds(i_sleep_seconds),
        .i_now_ticks    (i_now_ticks),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_woken_id     (o_woken_id),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic t_result result_of(t_status st, logic [TASK_W-1:0] id, logic last);
        t_result r;
        r.status = st;
        r.woken_id = id;
        r.last = last;
        return r;
    endfunction

    // fills fresh_results with what the block must answer to one transaction
    function automatic void predict_wakeups(t_wake_req req);
        logic [63:0]       span;
        logic [64:0]       sum;
        logic [TIME_W-1:0] wake;
        int                pos;
        int                due;
        fresh_results.delete();
        if (req.op == OP_SLEEP) begin
            if (req.secs[SECS_W-1]) begin
                fresh_results.push_back(result_of(ST_NEGATIVE, '0, 1'b1));
            end else if (queued_count >= QDEPTH) begin
                fresh_results.push_back(result_of(ST_FULL, '0, 1'b1));
            end else begin
                span = 64'(req.secs[SECS_W-2:0]) * 64'(rate_tps);
                sum = 65'(req.now) + 65'(span);
                wake = (sum > 65'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];
                pos = 0;
                while (pos < queued_count && queued_wake[pos] <= wake)
                    pos++;
                for (int i = queued_count; i > pos; i--) begin
                    queued_wake[i] = queued_wake[i-1];
                    queued_task[i] = queued_task[i-1];
                end
                queued_wake[pos] = wake;
                queued_task[pos] = req.task_id;
                queued_count++;
                fresh_results.push_back(result_of(ST_ACCEPTED, '0, 1'b1));
            end
        end else begin
            due = 0;
            while (due < queued_count && queued_wake[due] <= req.now)
                due++;
            if (due == 0) begin
                fresh_results.push_back(result_of(ST_NONE, '0, 1'b1));
            end else begin
                for (int i = 0; i < due; i++)
                    fresh_results.push_back(result_of(ST_WOKEN, queued_task[i], i == due - 1));
                for (int i = due; i < queued_count; i++) begin
                    queued_wake[i-due] = queued_wake[i];
                    queued_task[i-due] = queued_task[i];
                end
                queued_count -= due;
            end
        end
    endfunction

    // mostly a well-behaved clock moving forward, with some noise on every field
    function automatic t_wake_req next_random_req(int sleep_pct, int step_max);
        t_wake_req   req;
        logic [63:0] raw;
        int          pick;
        int          secs_sel;
        pick = $urandom_range(0, 99);
        req.task_id = TASK_W'($urandom_range(0, 63));
        req.secs = '0;
        if (pick < sleep_pct) begin
            req.op = OP_SLEEP;
            secs_sel = $urandom_range(0, 9);
            if (secs_sel <= 6)
                req.secs = SECS_W'($urandom_range(0, 8));
            else if (secs_sel == 7)
                req.secs = SECS_W'($urandom_range(0, 32767));
            else if (secs_sel == 8)
                req.secs = SECS_W'($urandom_range(32768, 65535));
            else
                req.secs = SECS_W'($urandom_range(9, 200));
            cur_now += 64'($urandom_range(0, 3));
            req.now = cur_now[TIME_W-1:0];
        end else if (pick < 92) begin
            req.op = OP_TICK;
            req.secs = SECS_W'($urandom_range(0, 65535));
            cur_now += 64'(rate_tps) * 64'($urandom_range(0, step_max))
                     + 64'($urandom_range(0, 999));
            req.now = cur_now[TIME_W-1:0];
        end else begin
            raw = {$urandom, $urandom};
            req.op = t_op'($urandom_range(0, 1));
            req.secs = SECS_W'($urandom_range(0, 65535));
            req.now = raw[TIME_W-1:0];
        end
        return req;
    endfunction

    // sender: bursts of back-to-back transactions with random gaps between
    task automatic offer(t_wake_req req);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        i_in_valid <= 1'b1;
        i_op <= req.op;
        i_task_id <= req.task_id;
        i_sleep_seconds <= req.secs;
        i_now_ticks <= req.now;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        burst_left--;
    endtask

    task automatic submit(t_wake_req req, logic typed, t_result res);
        offer(req);
        predict_wakeups(req);
        if (typed)
            awaited_results.push_back(res);
        else
            foreach (fresh_results[i]) awaited_results.push_back(fresh_results[i]);
    endtask

    task automatic wait_drained();
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rate(logic [TPS_W-1:0] value);
        i_in_valid <= 1'b0;
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        rate_tps = value;
    endtask

    task automatic run_phase(logic [TPS_W-1:0] tps, int count, int sleep_pct, int step_max);
        write_rate(tps);
        repeat (count) submit(next_random_req(sleep_pct, step_max), 1'b0, UNTYPED);
    endtask

    // result checker and output stall pattern
    always @(posedge i_clk) begin : result_check
        t_result            want;
        static t_stall_mode stall_mode = STALL_NONE;
        static int          stall_left = 0;
        static int          stall_phase = 0;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                $error("result with nothing awaited: status %0d woken_id %0d last %0d",
                       o_status, o_woken_id, o_last);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_woken_id !== want.woken_id) begin
                    $error("woken_id: expected %0d, got %0d", want.woken_id, o_woken_id);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    fail_count++;
                end
            end
        end
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= (stall_phase % 3 == 0);
        endcase
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("sleep_wakeup_timer_queue_top_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // rate stays at its reset value for the whole table
        directed_rows = '{
            '{'{OP_TICK,  6'd0,  16'h0000, 48'd0},        1'b1, '{ST_NONE, 6'd0, 1'b1}},
            '{'{OP_SLEEP, 6'd63, 16'h8000, 48'd0},        1'b1, '{ST_NEGATIVE, 6'd0, 1'b1}},
            '{'{OP_SLEEP, 6'd0,  16'hFFFF, TIME_MAX},     1'b1, '{ST_NEGATIVE, 6'd0, 1'b1}},
            '{'{OP_SLEEP, 6'd5,  16'h0000, 48'd1000},     1'b1, '{ST_ACCEPTED, 6'd0, 1'b1}},
            '{'{OP_TICK,  6'd0,  16'h0000, 48'd999},      1'b1, '{ST_NONE, 6'd0, 1'b1}},
            '{'{OP_TICK,  6'd0,  16'h0000, 48'd1000},     1'b1, '{ST_WOKEN, 6'd5, 1'b1}},
            // two equal wake times, then an earlier one slotted ahead of both
            '{'{OP_SLEEP, 6'd10, 16'h0001, 48'd0},        1'b1, '{ST_ACCEPTED, 6'd0, 1'b1}},
            '{'{OP_SLEEP, 6'd11, 16'h0001, 48'd0},        1'b1, '{ST_ACCEPTED, 6'd0, 1'b1}},
            '{'{OP_SLEEP, 6'd12, 16'h0000, 48'd500000},   1'b1, '{ST_ACCEPTED, 6'd0, 1'b1}},
            // wake time saturates at the top of the time range
            '{'{OP_SLEEP, 6'd63, 16'h7FFF, TIME_MAX},     1'b1, '{ST_ACCEPTED, 6'd0, 1'b1}},
            '{'{OP_SLEEP, 6'd20, 16'h7FFF, 48'd0},        1'b1, '{ST_ACCEPTED, 6'd0, 1'b1}},
            '{'{OP_TICK,  6'd0,  16'h0000, 48'd1000000},  1'b0, UNTYPED},
            '{'{OP_TICK,  6'd0,  16'h0000, TIME_MAX - 1}, 1'b0, UNTYPED},
            '{'{OP_TICK,  6'd0,  16'h0000, TIME_MAX},     1'b0, UNTYPED},
            '{'{OP_SLEEP, 6'd42, 16'h0000, TIME_MAX},     1'b1, '{ST_ACCEPTED, 6'd0, 1'b1}},
            // id and seconds carry junk on a tick
            '{'{OP_TICK,  6'd33, 16'hFFFF, TIME_MAX},     1'b0, UNTYPED}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            submit(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);

        run_phase(24'd1, 20, 50, 10);
        // zero rate: every wake time is the sleep's own time
        run_phase(24'd0, 20, 50, 2);
        run_phase(24'hFFFFFF, 20, 50, 4);
        // sleeps only and little time passing, so the queue fills up
        run_phase(24'($urandom_range(1, 2000000)), 100, 100, 0);
        run_phase(TPS_RESET, 25, 40, 40);

        i_in_valid <= 1'b0;
        wait_drained();
        if (fail_count == 0)
            $display("sleep_wakeup_timer_queue_top_test OK");
        else
            $display("sleep_wakeup_timer_queue_top_test NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/swtq_pkg.sv
rtl/swtq_cmd_fifo.sv
rtl/swtq_front.sv
rtl/swtq_back.sv
rtl/sleep_wakeup_timer_queue_top.sv
tb/sleep_wakeup_timer_queue_top_test.sv
